@@ design/crf_pkg.sv @@
package crf_pkg;

   // default parameter values
   localparam int PaletteDepthDefault = 256;
   localparam int BitmapSideDefault   = 16;

   // number of palette entries whose reset colour comes from default_colour
   localparam int DefaultColours = 16;

   // byte returned for offsets with nothing behind them
   localparam logic [7:0] UNMAPPED_BYTE = 8'hCC;

   // cursor size ceiling
   localparam logic [7:0] SIZE_LIMIT = 8'h20;

   // request codes
   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_MOTION = 3'd2,
      OP_BUTTON = 3'd3,
      OP_WHEEL  = 3'd4,
      OP_ACK    = 3'd5,
      OP_RSVD6  = 3'd6,
      OP_RSVD7  = 3'd7
   } op_type;

   // register window offsets
   typedef enum logic [3:0] {
      REG_X_HI     = 4'd0,
      REG_X_LO     = 4'd1,
      REG_Y_HI     = 4'd2,
      REG_Y_LO     = 4'd3,
      REG_HOT_X    = 4'd4,
      REG_HOT_Y    = 4'd5,
      REG_SIZE     = 4'd6,
      REG_SCROLL   = 4'd7,
      REG_BUTTONS  = 4'd8,
      REG_PAL_IDX  = 4'd9,
      REG_PAL_HI   = 4'd10,
      REG_PAL_LO   = 4'd11,
      REG_BMP_IDX  = 4'd12,
      REG_BMP_DATA = 4'd13,
      REG_RSVD14   = 4'd14,
      REG_RSVD15   = 4'd15
   } reg_offset_type;

   // configuration register indexes
   localparam logic [1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // palette lane write strobes
   typedef struct packed {
      logic hi;
      logic lo;
   } pal_wr_type;

   // reset colours of the first palette entries
   function automatic logic [15:0] default_colour(input logic [3:0] idx);
      logic [15:0] c;
      unique case (idx)
         4'd0:    c = 16'h0000;
         4'd1:    c = 16'h0005;
         4'd2:    c = 16'h000A;
         4'd3:    c = 16'h000F;
         4'd4:    c = 16'hFFFF;
         4'd5:    c = 16'hCCCF;
         4'd6:    c = 16'h555F;
         4'd7:    c = 16'h00CF;
         4'd8:    c = 16'h0C0F;
         4'd9:    c = 16'hC00F;
         4'd10:   c = 16'h00FF;
         4'd11:   c = 16'h0F0F;
         4'd12:   c = 16'h0FFF;
         4'd13:   c = 16'hF0FF;
         4'd14:   c = 16'hFF0F;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

endpackage

@@ design/crf_palette_mem.sv @@
module crf_palette_mem
   import crf_pkg::*;
#(
   parameter int PALETTE_DEPTH = PaletteDepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  pal_wr_type                       wr,
   input  logic [$clog2(PALETTE_DEPTH)-1:0] addr,
   input  logic [7:0]                       wr_data,
   output logic                             clearing,
   output logic [7:0]                       rd_hi,
   output logic [7:0]                       rd_lo
);

   localparam int AW = $clog2(PALETTE_DEPTH);

   // one memory per byte lane, so a lane write needs no read-modify-write
   logic [7:0] hi_mem [PALETTE_DEPTH];
   logic [7:0] lo_mem [PALETTE_DEPTH];

   logic [7:0]    hi_q_ff;
   logic [7:0]    lo_q_ff;
   logic          fill_ff, fill_in;
   logic [AW-1:0] fill_addr_ff, fill_addr_in;
   logic [15:0]   dflt;
   logic [AW-1:0] mem_addr;
   logic          hi_we, lo_we;
   logic [7:0]    hi_wd, lo_wd;

   // reset colour of the entry being filled
   always_comb begin
      if ({{(16 - AW){1'b0}}, fill_addr_ff} < 16'(DefaultColours)) begin
         dflt = default_colour(4'(fill_addr_ff));
      end else begin
         dflt = 16'h0000;
      end
   end

   // fill pass, one entry a cycle from the first to the last
   always_comb begin
      fill_in      = fill_ff;
      fill_addr_in = fill_addr_ff;
      if (fill_ff) begin
         fill_addr_in = fill_addr_ff + AW'(1);
         if (fill_addr_ff == AW'(PALETTE_DEPTH - 1)) begin
            fill_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= 1'b1;
         fill_addr_ff <= '0;
      end else begin
         fill_ff      <= fill_in;
         fill_addr_ff <= fill_addr_in;
      end
   end

   // fill pass takes the memory port while it runs
   assign mem_addr = fill_ff ? fill_addr_ff : addr;
   assign hi_we    = fill_ff || wr.hi;
   assign lo_we    = fill_ff || wr.lo;
   assign hi_wd    = fill_ff ? dflt[15:8] : wr_data;
   assign lo_wd    = fill_ff ? dflt[7:0] : wr_data;

   // lane memories, write and registered read
   always_ff @(posedge clock) begin
      if (hi_we) begin
         hi_mem[mem_addr] <= hi_wd;
      end
      if (lo_we) begin
         lo_mem[mem_addr] <= lo_wd;
      end
      hi_q_ff <= hi_mem[mem_addr];
      lo_q_ff <= lo_mem[mem_addr];
   end

   assign clearing = fill_ff;
   assign rd_hi    = hi_q_ff;
   assign rd_lo    = lo_q_ff;

endmodule

@@ design/crf_bitmap_mem.sv @@
module crf_bitmap_mem
   import crf_pkg::*;
#(
   parameter int BITMAP_SIDE = BitmapSideDefault
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       wr_en,
   input  logic [$clog2(BITMAP_SIDE*BITMAP_SIDE)-1:0] addr,
   input  logic [7:0]                                 wr_data,
   output logic [7:0]                                 rd_data
);

   localparam int Cells = BITMAP_SIDE * BITMAP_SIDE;

   logic [7:0]       bmp_mem [Cells];
   logic [Cells-1:0] valid_ff;
   logic [7:0]       q_ff;
   logic             ok_ff;

   // bitmap memory, write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bmp_mem[addr] <= wr_data;
      end
      q_ff <= bmp_mem[addr];
   end

   // written marks; an unwritten cell reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[addr] <= 1'b1;
         end
         ok_ff <= valid_ff[addr];
      end
   end

   assign rd_data = ok_ff ? q_ff : 8'h00;

endmodule

@@ design/cursor_register_file.sv @@
// Cursor register file: a 16-byte register window for a mouse cursor, fed
// with bus reads and writes, pointer motion, button, wheel and redraw
// acknowledge requests.
// Request channel: a request is taken on a rising edge with start high and
// busy low. Outside the palette fill after reset busy stays low, so a
// request may be issued every cycle.
// Response channel: exactly one response per request, on the cycle after
// the request is taken, marked by rsp_valid for that one cycle. The
// receiver cannot stall; it must take the response in that cycle.
// The palette and bitmap memories, addressed by the index registers of the
// window, have a registered read. While busy is low one request is taken
// per cycle; a write lands before the next read is clocked, so back-to-back
// accesses to one entry need no interlock.
// Configuration: csr_valid/csr_ready write channel, index 0 screen width,
// index 1 screen height; csr_ready is always high. Write only while idle.
// Reset (synchronous) clears the window registers and the dirty mark, sets
// screen width and height to 255, clears the bitmap at once through per-cell
// written marks, and starts a fill pass that writes the palette reset
// colours, one entry a cycle, with busy held high until it ends.
module cursor_register_file
   import crf_pkg::*;
#(
   parameter int PALETTE_DEPTH = PaletteDepthDefault,
   parameter int BITMAP_SIDE   = BitmapSideDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_offset,
   input  logic [7:0]  req_wr_data,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic [7:0]  req_button_num,
   input  logic        req_pressed,
   input  logic [7:0]  req_clicks,
   input  logic signed [7:0] req_wheel,
   output logic        rsp_valid,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_cursor_dirty,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wr_data
);

   localparam int Cells = BITMAP_SIDE * BITMAP_SIDE;
   localparam int PalAw = $clog2(PALETTE_DEPTH);
   localparam int BmpAw = $clog2(Cells);

   // response byte source
   typedef enum logic [1:0] {
      SRC_REG,
      SRC_PAL_HI,
      SRC_PAL_LO,
      SRC_BMP
   } src_type;

   logic [7:0] screen_w_ff, screen_h_ff;
   logic [7:0] cursor_x_ff, cursor_x_in;
   logic [7:0] cursor_y_ff, cursor_y_in;
   logic [7:0] hot_x_ff, hot_x_in;
   logic [7:0] hot_y_ff, hot_y_in;
   logic [5:0] size_ff, size_in;
   logic [7:0] scroll_ff, scroll_in;
   logic [7:0] buttons_ff, buttons_in;
   logic [7:0] pal_idx_ff, pal_idx_in;
   logic [7:0] bmp_idx_ff, bmp_idx_in;
   logic       dirty_ff, dirty_in;
   logic       rsp_valid_ff;
   src_type    src_ff, src_in;
   logic [7:0] reg_data_ff, reg_data_in;

   logic       accept;
   logic       pal_ok;
   logic       bmp_ok;
   logic       pal_clearing;
   pal_wr_type pal_wr;
   logic       bmp_wr;
   logic [7:0] pal_hi, pal_lo, bmp_q;
   logic [2:0] btn_bit;
   op_type     op;
   reg_offset_type offs;

   // clamp a signed coordinate into 0 .. size-1, size 0 taken as 1
   function automatic logic [7:0] clamp_axis(input logic [15:0] v,
                                             input logic [7:0] size);
      logic [7:0] lim_m1;
      logic [7:0] r;
      lim_m1 = (size == 8'd0) ? 8'd0 : size - 8'd1;
      if (v[15]) begin
         r = 8'd0;
      end else if (v[14:8] != 7'd0 || v[7:0] > lim_m1) begin
         r = lim_m1;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // remainder by seven through octal digit folding
   function automatic logic [2:0] mod7(input logic [7:0] x);
      logic [4:0] s1;
      logic [3:0] s2;
      logic [2:0] r;
      s1 = 5'(x[7:6]) + 5'(x[5:3]) + 5'(x[2:0]);
      s2 = 4'(s1[4:3]) + 4'(s1[2:0]);
      r  = (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
      return r;
   endfunction

   assign busy      = pal_clearing;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign op        = op_type'(req_op);
   assign offs      = reg_offset_type'(req_offset);
   assign pal_ok    = {1'b0, pal_idx_ff} < 9'(PALETTE_DEPTH);
   assign bmp_ok    = {1'b0, bmp_idx_ff} < 9'(Cells);
   assign btn_bit   = mod7(req_button_num);

   // memory write strobes
   always_comb begin
      pal_wr.hi = accept && op == OP_WRITE && offs == REG_PAL_HI && pal_ok;
      pal_wr.lo = accept && op == OP_WRITE && offs == REG_PAL_LO && pal_ok;
      bmp_wr    = accept && op == OP_WRITE && offs == REG_BMP_DATA && bmp_ok;
   end

   crf_palette_mem #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr       (pal_wr),
      .addr     (pal_idx_ff[PalAw-1:0]),
      .wr_data  (req_wr_data),
      .clearing (pal_clearing),
      .rd_hi    (pal_hi),
      .rd_lo    (pal_lo)
   );

   crf_bitmap_mem #(
      .BITMAP_SIDE(BITMAP_SIDE)
   ) u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (bmp_wr),
      .addr    (bmp_idx_ff[BmpAw-1:0]),
      .wr_data (req_wr_data),
      .rd_data (bmp_q)
   );

   // request decode and next register values
   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      hot_x_in    = hot_x_ff;
      hot_y_in    = hot_y_ff;
      size_in     = size_ff;
      scroll_in   = scroll_ff;
      buttons_in  = buttons_ff;
      pal_idx_in  = pal_idx_ff;
      bmp_idx_in  = bmp_idx_ff;
      dirty_in    = dirty_ff || pal_wr.hi || pal_wr.lo || bmp_wr;
      src_in      = SRC_REG;
      reg_data_in = 8'h00;
      if (accept) begin
         unique case (op)
            OP_READ: begin
               unique case (offs)
                  REG_X_LO:     reg_data_in = cursor_x_ff;
                  REG_Y_LO:     reg_data_in = cursor_y_ff;
                  REG_HOT_X:    reg_data_in = hot_x_ff;
                  REG_HOT_Y:    reg_data_in = hot_y_ff;
                  REG_SIZE:     reg_data_in = {2'b00, size_ff};
                  REG_BUTTONS:  reg_data_in = buttons_ff;
                  REG_PAL_IDX:  reg_data_in = pal_idx_ff;
                  REG_PAL_HI:   src_in = pal_ok ? SRC_PAL_HI : SRC_REG;
                  REG_PAL_LO:   src_in = pal_ok ? SRC_PAL_LO : SRC_REG;
                  REG_BMP_IDX:  reg_data_in = bmp_idx_ff;
                  REG_BMP_DATA: src_in = bmp_ok ? SRC_BMP : SRC_REG;
                  REG_X_HI, REG_Y_HI: reg_data_in = 8'h00;
                  default:      reg_data_in = UNMAPPED_BYTE;
               endcase
            end
            OP_WRITE: begin
               unique case (offs)
                  REG_HOT_X:   hot_x_in = req_wr_data;
                  REG_HOT_Y:   hot_y_in = req_wr_data;
                  REG_SIZE: begin
                     size_in = (req_wr_data >= SIZE_LIMIT) ? 6'(SIZE_LIMIT)
                                                           : req_wr_data[5:0];
                  end
                  REG_SCROLL:  scroll_in = req_wr_data;
                  REG_PAL_IDX: pal_idx_in = req_wr_data;
                  REG_BMP_IDX: bmp_idx_in = req_wr_data;
                  default: ;
               endcase
            end
            OP_MOTION: begin
               cursor_x_in = clamp_axis(req_pos_x, screen_w_ff);
               cursor_y_in = clamp_axis(req_pos_y, screen_h_ff);
            end
            OP_BUTTON: begin
               buttons_in = 8'h00;
               if (req_pressed) begin
                  if (btn_bit != 3'd0) begin
                     buttons_in = 8'(8'd1 << (btn_bit - 3'd1));
                  end
                  buttons_in[7:6] = req_clicks[1:0];
               end
            end
            OP_WHEEL: scroll_in = req_wheel;
            OP_ACK:   dirty_in  = 1'b0;
            default: ;
         endcase
      end
   end

   // window registers and response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_w_ff  <= 8'd255;
         screen_h_ff  <= 8'd255;
         cursor_x_ff  <= 8'h00;
         cursor_y_ff  <= 8'h00;
         hot_x_ff     <= 8'h00;
         hot_y_ff     <= 8'h00;
         size_ff      <= 6'h00;
         scroll_ff    <= 8'h00;
         buttons_ff   <= 8'h00;
         pal_idx_ff   <= 8'h00;
         bmp_idx_ff   <= 8'h00;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_ff       <= SRC_REG;
         reg_data_ff  <= 8'h00;
      end else begin
         if (csr_valid && csr_ready && csr_index == CSR_SCREEN_WIDTH) begin
            screen_w_ff <= csr_wr_data;
         end
         if (csr_valid && csr_ready && csr_index == CSR_SCREEN_HEIGHT) begin
            screen_h_ff <= csr_wr_data;
         end
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         hot_x_ff     <= hot_x_in;
         hot_y_ff     <= hot_y_in;
         size_ff      <= size_in;
         scroll_ff    <= scroll_in;
         buttons_ff   <= buttons_in;
         pal_idx_ff   <= pal_idx_in;
         bmp_idx_ff   <= bmp_idx_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= accept;
         src_ff       <= src_in;
         reg_data_ff  <= reg_data_in;
      end
   end

   // response byte select
   always_comb begin
      unique case (src_ff)
         SRC_PAL_HI: rsp_read_data = pal_hi;
         SRC_PAL_LO: rsp_read_data = pal_lo;
         SRC_BMP:    rsp_read_data = bmp_q;
         default:    rsp_read_data = reg_data_ff;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_dirty = dirty_ff;

endmodule

@@ bench/tb_cursor_register_file.sv @@
`default_nettype none

module tb_cursor_register_file;
   import crf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CycleLimit  = 100000;
   localparam int BitmapCells = BitmapSideDefault * BitmapSideDefault;

   // one request as it sits on the request ports
   typedef struct packed {
      op_type              op;
      reg_offset_type      offset;
      logic [7:0]          wr_data;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic [7:0]          button_num;
      logic                pressed;
      logic [7:0]          clicks;
      logic signed [7:0]   wheel;
   } cursor_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       cursor_dirty;
   } cursor_rsp_type;

   // directed row: request plus an optional hand-written response
   typedef struct packed {
      cursor_req_type req;
      logic           typed;
      cursor_rsp_type rsp;
   } directed_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start;
   logic           busy;
   cursor_req_type req_now;
   logic           typed_now;
   cursor_rsp_type typed_rsp_now;
   logic           rsp_valid;
   logic [7:0]     rsp_read_data;
   logic           rsp_cursor_dirty;
   logic           csr_valid;
   logic           csr_ready;
   logic [1:0]     csr_index;
   logic [7:0]     csr_wr_data;

   int               error_count = 0;
   int               cycle_count = 0;
   cursor_rsp_type   cursor_rsp_queue[$];
   directed_row_type directed_rows[$];

   // shadow copy of the cursor state
   logic [7:0]  scr_w, scr_h;
   logic [7:0]  cur_x, cur_y, hot_x, hot_y, cur_size, scroll_byte, btn_flags;
   logic [7:0]  pal_sel, bmp_sel;
   logic [15:0] pal_mem [PaletteDepthDefault];
   logic [7:0]  bmp_mem [BitmapCells];
   logic        dirty;

   localparam logic [15:0] ResetColours [16] = '{
      16'h0000, 16'h0005, 16'h000A, 16'h000F, 16'hFFFF, 16'hCCCF, 16'h555F, 16'h00CF,
      16'h0C0F, 16'hC00F, 16'h00FF, 16'h0F0F, 16'h0FFF, 16'hF0FF, 16'hFF0F, 16'hFFFF
   };

   cursor_register_file u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_now.op),
      .req_offset       (req_now.offset),
      .req_wr_data      (req_now.wr_data),
      .req_pos_x        (req_now.pos_x),
      .req_pos_y        (req_now.pos_y),
      .req_button_num   (req_now.button_num),
      .req_pressed      (req_now.pressed),
      .req_clicks       (req_now.clicks),
      .req_wheel        (req_now.wheel),
      .rsp_valid        (rsp_valid),
      .rsp_read_data    (rsp_read_data),
      .rsp_cursor_dirty (rsp_cursor_dirty),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CycleLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // queue an expected response behind the ones outstanding
   function automatic void add_expected(cursor_rsp_type e);
      cursor_rsp_queue.insert(cursor_rsp_queue.size(), e);
   endfunction

   // append a row to the directed table
   function automatic void add_row(directed_row_type d);
      directed_rows.insert(directed_rows.size(), d);
   endfunction

   // clamp a signed pixel coordinate onto the screen
   function automatic logic [7:0] clamp_to_screen(logic signed [15:0] c, logic [7:0] span);
      int lim;
      lim = (span == 8'd0) ? 1 : int'(span);
      if (c < 0) return 8'd0;
      if (c >= lim) return 8'(lim - 1);
      return c[7:0];
   endfunction

   // advance the shadow state by one request and return its response
   function automatic cursor_rsp_type predict_cursor_rsp(cursor_req_type r);
      cursor_rsp_type o;
      int             b;
      o.read_data = 8'h00;
      case (r.op)
         OP_READ: begin
            case (r.offset)
               REG_X_LO:     o.read_data = cur_x;
               REG_Y_LO:     o.read_data = cur_y;
               REG_HOT_X:    o.read_data = hot_x;
               REG_HOT_Y:    o.read_data = hot_y;
               REG_SIZE:     o.read_data = cur_size;
               REG_BUTTONS:  o.read_data = btn_flags;
               REG_PAL_IDX:  o.read_data = pal_sel;
               REG_PAL_HI:   if (pal_sel < PaletteDepthDefault) o.read_data = pal_mem[pal_sel][15:8];
               REG_PAL_LO:   if (pal_sel < PaletteDepthDefault) o.read_data = pal_mem[pal_sel][7:0];
               REG_BMP_IDX:  o.read_data = bmp_sel;
               REG_BMP_DATA: if (bmp_sel < BitmapCells) o.read_data = bmp_mem[bmp_sel];
               REG_SCROLL, REG_RSVD14, REG_RSVD15: o.read_data = UNMAPPED_BYTE;
               default:      o.read_data = 8'h00;
            endcase
         end
         OP_WRITE: begin
            case (r.offset)
               REG_HOT_X:   hot_x = r.wr_data;
               REG_HOT_Y:   hot_y = r.wr_data;
               REG_SIZE:    cur_size = (r.wr_data >= SIZE_LIMIT) ? SIZE_LIMIT : r.wr_data;
               REG_SCROLL:  scroll_byte = r.wr_data;
               REG_PAL_IDX: pal_sel = r.wr_data;
               REG_PAL_HI: begin
                  if (pal_sel < PaletteDepthDefault) begin
                     pal_mem[pal_sel][15:8] = r.wr_data;
                     dirty = 1'b1;
                  end
               end
               REG_PAL_LO: begin
                  if (pal_sel < PaletteDepthDefault) begin
                     pal_mem[pal_sel][7:0] = r.wr_data;
                     dirty = 1'b1;
                  end
               end
               REG_BMP_IDX: bmp_sel = r.wr_data;
               REG_BMP_DATA: begin
                  if (bmp_sel < BitmapCells) begin
                     bmp_mem[bmp_sel] = r.wr_data;
                     dirty = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         OP_MOTION: begin
            cur_x = clamp_to_screen(r.pos_x, scr_w);
            cur_y = clamp_to_screen(r.pos_y, scr_h);
         end
         OP_BUTTON: begin
            // multiples of seven map to no button bit
            b = int'(r.button_num) % 7;
            btn_flags = 8'h00;
            if (r.pressed) begin
               if (b != 0) btn_flags[b-1] = 1'b1;
               btn_flags[7:6] = r.clicks[1:0];
            end
         end
         OP_WHEEL: scroll_byte = r.wheel;
         OP_ACK:   dirty = 1'b0;
         default: ;
      endcase
      o.cursor_dirty = dirty;
      return o;
   endfunction

   // request acceptance and response checking
   always @(posedge clock) begin : watch
      cursor_rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            want = predict_cursor_rsp(req_now);
            if (typed_now) want = typed_rsp_now;
            add_expected(want);
         end
         if (rsp_valid) begin
            if (cursor_rsp_queue.size() == 0) begin
               $display("%0t: response with no request outstanding (read_data %h dirty %b)",
                        $time, rsp_read_data, rsp_cursor_dirty);
               error_count++;
            end else begin
               want = cursor_rsp_queue.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $display("%0t: read_data expected %h actual %h",
                           $time, want.read_data, rsp_read_data);
                  error_count++;
               end
               if (rsp_cursor_dirty !== want.cursor_dirty) begin
                  $display("%0t: cursor_dirty expected %b actual %b",
                           $time, want.cursor_dirty, rsp_cursor_dirty);
                  error_count++;
               end
            end
         end
      end
   end

   function automatic directed_row_type row(op_type op, reg_offset_type off, logic [7:0] wd,
                                            int px, int py, logic [7:0] bn, logic pr,
                                            logic [7:0] ck, int wh, logic typed,
                                            logic [7:0] erd, logic ed);
      directed_row_type d;
      d.req.op         = op;
      d.req.offset     = off;
      d.req.wr_data    = wd;
      d.req.pos_x      = 16'(px);
      d.req.pos_y      = 16'(py);
      d.req.button_num = bn;
      d.req.pressed    = pr;
      d.req.clicks     = ck;
      d.req.wheel      = 8'(wh);
      d.typed          = typed;
      d.rsp.read_data    = erd;
      d.rsp.cursor_dirty = ed;
      return d;
   endfunction

   // coordinates mostly around the screen, sometimes anywhere
   function automatic logic signed [15:0] rand_coord();
      int v;
      if ($urandom_range(0, 3) == 0) return 16'($urandom);
      v = $urandom_range(0, 320) - 20;
      return 16'(v);
   endfunction

   function automatic cursor_req_type rand_request();
      cursor_req_type r;
      int             pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      r.op = OP_READ;
      else if (pick < 58) r.op = OP_WRITE;
      else if (pick < 72) r.op = OP_MOTION;
      else if (pick < 84) r.op = OP_BUTTON;
      else if (pick < 90) r.op = OP_WHEEL;
      else if (pick < 96) r.op = OP_ACK;
      else                r.op = ($urandom_range(0, 1) != 0) ? OP_RSVD7 : OP_RSVD6;
      r.offset     = reg_offset_type'($urandom_range(0, 15));
      r.wr_data    = 8'($urandom);
      r.pos_x      = rand_coord();
      r.pos_y      = rand_coord();
      r.button_num = 8'($urandom);
      r.pressed    = 1'($urandom);
      r.clicks     = 8'($urandom);
      r.wheel      = 8'($urandom);
      return r;
   endfunction

   // issue one request, with an optional idle burst in front of it
   task automatic send_request(cursor_req_type r, logic typed, cursor_rsp_type want,
                               bit allow_idle);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      start         <= 1'b1;
      req_now       <= r;
      typed_now     <= typed;
      typed_rsp_now <= want;
      do @(posedge clock); while (busy);
   endtask

   // wait for all responses, then the pipeline latency
   task automatic drain();
      while (cursor_rsp_queue.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // valid is left high; the caller drops it after the last write
   task automatic write_csr(logic [1:0] idx, logic [7:0] value);
      csr_valid   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_SCREEN_WIDTH) scr_w = value;
      else if (idx == CSR_SCREEN_HEIGHT) scr_h = value;
   endtask

   // random traffic, mostly index/data sequences on the palette and bitmap
   task automatic random_phase(int count, bit allow_idle);
      cursor_req_type r;
      cursor_rsp_type none;
      reg_offset_type data_reg;
      int             kind;
      int             sent;
      none = '0;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 35) begin
            kind = $urandom_range(0, 2);
            data_reg = (kind == 0) ? REG_PAL_HI : (kind == 1) ? REG_PAL_LO : REG_BMP_DATA;
            r = rand_request();
            r.op      = OP_WRITE;
            r.offset  = (kind == 2) ? REG_BMP_IDX : REG_PAL_IDX;
            r.wr_data = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 19));
            send_request(r, 1'b0, none, allow_idle);
            r = rand_request();
            r.op     = ($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ;
            r.offset = data_reg;
            send_request(r, 1'b0, none, allow_idle);
            r = rand_request();
            r.op     = OP_READ;
            r.offset = ($urandom_range(0, 1) != 0) ? data_reg : reg_offset_type'($urandom_range(9, 13));
            send_request(r, 1'b0, none, allow_idle);
            sent += 3;
         end else begin
            send_request(rand_request(), 1'b0, none, allow_idle);
            sent++;
         end
      end
      start <= 1'b0;
   endtask

   // main sequence
   initial begin : main
      directed_row_type d;
      start         <= 1'b0;
      req_now       <= '0;
      typed_now     <= 1'b0;
      typed_rsp_now <= '0;
      csr_valid     <= 1'b0;
      csr_index     <= CSR_SCREEN_WIDTH;
      csr_wr_data   <= 8'h00;

      // reset state of the shadow model
      scr_w = 8'd255; scr_h = 8'd255;
      cur_x = '0; cur_y = '0; hot_x = '0; hot_y = '0; cur_size = '0;
      scroll_byte = '0; btn_flags = '0; pal_sel = '0; bmp_sel = '0; dirty = 1'b0;
      for (int i = 0; i < PaletteDepthDefault; i++)
         pal_mem[i] = (i < DefaultColours) ? ResetColours[i] : 16'h0000;
      for (int i = 0; i < BitmapCells; i++) bmp_mem[i] = 8'h00;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, unmapped reads, clamps, button flags, dirty mark
      add_row(row(OP_READ,   REG_X_HI,     8'h00, 0, 0, 0, 0, 0, 0, 1, 8'h00, 0));
      add_row(row(OP_READ,   REG_SCROLL,   8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hCC, 0));
      add_row(row(OP_READ,   REG_RSVD14,   8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hCC, 0));
      add_row(row(OP_READ,   REG_RSVD15,   8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hCC, 0));
      add_row(row(OP_WRITE,  REG_PAL_IDX,  8'h04, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_READ,   REG_PAL_HI,   8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hFF, 0));
      add_row(row(OP_WRITE,  REG_SIZE,     8'hFF, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_READ,   REG_SIZE,     8'h00, 0, 0, 0, 0, 0, 0, 1, 8'h20, 0));
      add_row(row(OP_WRITE,  REG_SCROLL,   8'h5A, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_MOTION, REG_X_HI, 8'h00, -32768, 32767, 0, 0, 0, 0,
                  0, 8'h00, 0));
      add_row(row(OP_READ,   REG_X_LO,     8'h00, 0, 0, 0, 0, 0, 0, 1, 8'h00, 0));
      add_row(row(OP_READ,   REG_Y_LO,     8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hFE, 0));
      add_row(row(OP_BUTTON, REG_X_HI,     8'h00, 0, 0, 7, 1, 8'hFF, 0,
                  0, 8'h00, 0));
      add_row(row(OP_READ,   REG_BUTTONS,  8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hC0, 0));
      add_row(row(OP_BUTTON, REG_X_HI,     8'h00, 0, 0, 255, 1, 0, 0,
                  0, 8'h00, 0));
      add_row(row(OP_WHEEL,  REG_X_HI,     8'h00, 0, 0, 0, 0, 0, -128,
                  0, 8'h00, 0));
      add_row(row(OP_WRITE,  REG_BMP_IDX,  8'hFF, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_WRITE,  REG_BMP_DATA, 8'hA5, 0, 0, 0, 0, 0, 0, 1, 8'h00, 1));
      add_row(row(OP_READ,   REG_BMP_DATA, 8'h00, 0, 0, 0, 0, 0, 0, 1, 8'hA5, 1));
      add_row(row(OP_ACK,    REG_X_HI,     8'h00, 0, 0, 0, 0, 0, 0, 1, 8'h00, 0));
      add_row(row(OP_WRITE,  REG_PAL_LO,   8'h00, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_WRITE,  REG_X_HI,     8'hFF, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_RSVD7,  REG_X_HI,     8'h00, 0, 0, 0, 0, 0, 0, 1, 8'h00, 1));
      add_row(row(OP_WRITE,  REG_HOT_Y,    8'hFF, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));
      add_row(row(OP_READ,   REG_HOT_Y,    8'h00, 0, 0, 0, 0, 0, 0, 0, 8'h00, 0));

      foreach (directed_rows[i]) begin
         d = directed_rows[i];
         send_request(d.req, d.typed, d.rsp, 1'b1);
      end
      start <= 1'b0;
      drain();

      // smallest screen
      write_csr(CSR_SCREEN_WIDTH, 8'd1);
      write_csr(CSR_SCREEN_HEIGHT, 8'd1);
      csr_valid <= 1'b0;
      random_phase(120, 1'b1);
      drain();

      // zero size behaves as one pixel
      write_csr(CSR_SCREEN_WIDTH, 8'd0);
      write_csr(CSR_SCREEN_HEIGHT, 8'd0);
      csr_valid <= 1'b0;
      random_phase(60, 1'b1);
      drain();

      write_csr(CSR_SCREEN_WIDTH, 8'($urandom_range(1, 255)));
      write_csr(CSR_SCREEN_HEIGHT, 8'($urandom_range(1, 255)));
      csr_valid <= 1'b0;
      random_phase(130, 1'b1);
      drain();

      write_csr(CSR_SCREEN_WIDTH, 8'($urandom_range(1, 16)));
      write_csr(CSR_SCREEN_HEIGHT, 8'd255);
      csr_valid <= 1'b0;
      random_phase(130, 1'b1);
      drain();

      // full-width screen, back-to-back requests
      write_csr(CSR_SCREEN_WIDTH, 8'd255);
      write_csr(CSR_SCREEN_HEIGHT, 8'($urandom_range(200, 255)));
      csr_valid <= 1'b0;
      random_phase(180, 1'b0);

      while (cursor_rsp_queue.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ cursor_register_file.f @@
design/crf_pkg.sv
design/crf_palette_mem.sv
design/crf_bitmap_mem.sv
design/cursor_register_file.sv
bench/tb_cursor_register_file.sv
